// ----- hw/rtl/a2i_pkg.sv -----
// ----------------------------------------------------------------------------
// a2i_pkg
// Shared types, constants and the digit decoder for the string-to-integer
// parser.
// ----------------------------------------------------------------------------
package a2i_pkg;

  localparam int unsigned IndexBits = 16;
  localparam int unsigned ValueBits = 32;
  localparam int unsigned BaseBits  = 6;
  localparam int unsigned CharBits  = 8;

  localparam logic [CharBits-1:0] CharNul   = 8'h00;
  localparam logic [CharBits-1:0] CharSpace = 8'h20;
  localparam logic [CharBits-1:0] CharZero  = 8'h30;
  localparam logic [CharBits-1:0] CharLowX  = 8'h78;

  localparam logic [BaseBits-1:0] BaseAuto = 6'd0;
  localparam logic [BaseBits-1:0] BaseOne  = 6'd1;
  localparam logic [BaseBits-1:0] BaseMax  = 6'd36;
  localparam logic [BaseBits-1:0] BaseOct  = 6'd8;
  localparam logic [BaseBits-1:0] BaseDec  = 6'd10;
  localparam logic [BaseBits-1:0] BaseHex  = 6'd16;

  // Any code at or above the largest legal base never passes the digit test.
  localparam logic [BaseBits-1:0] NotDigit = 6'd63;

  typedef enum logic [2:0] {
    PhSkip    = 3'd0,
    PhZero    = 3'd1,
    PhDigits  = 3'd2,
    PhStopped = 3'd3,
    PhBad     = 3'd4
  } phase_e;

  typedef struct packed {
    phase_e                 phase;
    logic [BaseBits-1:0]    base;
    logic [ValueBits-1:0]   acc;
    logic [IndexBits-1:0]   pos;
    logic [IndexBits-1:0]   stop;
  } parse_state_t;

  typedef struct packed {
    logic [ValueBits-1:0] value;
    logic [IndexBits-1:0] end_index;
    logic                 bad_base;
  } parse_result_t;

  localparam parse_state_t StateClear = '{
    phase: PhSkip,
    base:  '0,
    acc:   '0,
    pos:   '0,
    stop:  '0
  };

  function automatic logic [BaseBits-1:0] digit_value(input logic [CharBits-1:0] c);
    logic [BaseBits-1:0] d;
    d = NotDigit;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = BaseBits'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      d = BaseBits'(c - 8'h41 + 8'd10);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      d = BaseBits'(c - 8'h61 + 8'd10);
    end
    return d;
  endfunction

  function automatic logic base_illegal(input logic [BaseBits-1:0] b);
    return (b == BaseOne) || (b > BaseMax);
  endfunction

endpackage

// ----- hw/rtl/ascii_to_integer_parser_unit.sv -----
// ----------------------------------------------------------------------------
// ascii_to_integer_parser_unit
// Streams characters in and emits one converted value per terminated string.
// ----------------------------------------------------------------------------
// A terminator's result goes through the input register, then the result
// register; it waits in the input register while an older result is held.
// Throughput: one character per cycle; the parse state updates in one pass.
// The input side stalls only while a result waits and a terminator is due.
// Reset clears the parse state, the base register and both valid flags.
module ascii_to_integer_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i,     // base_select
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,    // [7:0] char_code
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,    // [31:0] value, [47:32] end_index
  output logic        m_axis_tuser     // [0] bad_base
);
  import a2i_pkg::*;

  logic [BaseBits-1:0] base_sel_q;
  logic                in_v_q;
  logic [CharBits-1:0] in_char_q;
  parse_state_t        state_q, state_d;
  logic                out_v_q;
  parse_result_t       out_q;
  parse_result_t       step_res;
  logic                step_emit;
  logic                advance;

  a2i_step u_step (
    .char_i        (in_char_q),
    .base_select_i (base_sel_q),
    .state_i       (state_q),
    .state_o       (state_d),
    .emit_o        (step_emit),
    .result_o      (step_res)
  );

  // A terminator may move on only when the result register is free or draining.
  assign advance       = in_v_q && (!step_emit || !out_v_q || m_axis_tready);
  assign s_axis_tready = !in_v_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_sel_q <= BaseAuto;
    end else if (cfg_we_i) begin
      base_sel_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      state_q <= StateClear;
      out_v_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_v_q <= s_axis_tvalid;
      end
      if (advance) begin
        state_q <= state_d;
      end
      if (advance && step_emit) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_char_q <= s_axis_tdata;
    end
    if (advance && step_emit) begin
      out_q <= step_res;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {out_q.end_index, out_q.value};
  assign m_axis_tuser  = out_q.bad_base;

endmodule

// ----- hw/rtl/a2i_step.sv -----
// ----------------------------------------------------------------------------
// a2i_step
// Next-state logic for one character: prefix handling, digit accumulation,
// stop detection and the result at the terminator.
// ----------------------------------------------------------------------------
module a2i_step (
  input  logic [7:0]             char_i,
  input  logic [5:0]             base_select_i,
  input  a2i_pkg::parse_state_t  state_i,
  output a2i_pkg::parse_state_t  state_o,
  output logic                   emit_o,
  output a2i_pkg::parse_result_t result_o
);
  import a2i_pkg::*;

  logic [BaseBits-1:0]           base_use;
  logic                          take_en;
  logic [BaseBits-1:0]           digit;
  logic [ValueBits+BaseBits-1:0] prod;
  logic                          bad;
  parse_state_t                  nxt;

  assign digit = digit_value(char_i);
  assign prod  = state_i.acc * base_use;

  always_comb begin
    nxt      = state_i;
    base_use = state_i.base;
    take_en  = 1'b0;
    emit_o   = 1'b0;
    bad      = (state_i.phase == PhBad) ||
               (state_i.phase == PhSkip && base_illegal(base_select_i));
    result_o.bad_base  = bad;
    result_o.value     = bad ? '0 : state_i.acc;
    result_o.end_index = bad ? '0 :
                         (state_i.phase == PhStopped) ? state_i.stop : state_i.pos;

    if (char_i == CharNul) begin
      emit_o = 1'b1;
      nxt    = StateClear;
    end else begin
      unique case (state_i.phase)
        PhSkip: begin
          if (char_i != CharSpace) begin
            if (base_illegal(base_select_i)) begin
              nxt.phase = PhBad;
            end else if (base_select_i == BaseAuto) begin
              if (char_i == CharZero) begin
                nxt.phase = PhZero;
              end else begin
                base_use  = BaseDec;
                nxt.phase = PhDigits;
                take_en   = 1'b1;
              end
            end else begin
              base_use  = base_select_i;
              nxt.phase = PhDigits;
              take_en   = 1'b1;
            end
          end
        end
        PhZero: begin
          nxt.phase = PhDigits;
          if (char_i == CharLowX) begin
            base_use = BaseHex;
          end else begin
            base_use = BaseOct;
            take_en  = 1'b1;
          end
        end
        PhDigits: begin
          take_en = 1'b1;
        end
        default: begin
        end
      endcase
      nxt.base = base_use;

      if (take_en) begin
        if (digit < base_use) begin
          nxt.acc = prod[ValueBits-1:0] + ValueBits'(digit);
        end else begin
          nxt.stop  = state_i.pos;
          nxt.phase = PhStopped;
        end
      end

      // Position saturates at the all-ones index.
      if (state_i.pos != '1) begin
        nxt.pos = state_i.pos + 1'b1;
      end
    end
    state_o = nxt;
  end

endmodule
